FILE: rtl/fsl_pkg.sv
package fsl_pkg;

   localparam int HEAP_BYTES   = 4096;
   localparam int MAX_SEGMENTS = 16;
   localparam int ALIGN        = 8;
   localparam int HEADER_BYTES = 8;
   localparam int MIN_BLOCK    = 16;

   localparam int HDR_SPAN    = (HEADER_BYTES + ALIGN - 1) / ALIGN * ALIGN;
   localparam int MIN_SPAN    = (MIN_BLOCK + ALIGN - 1) / ALIGN * ALIGN;
   localparam int ALIGN_SH    = $clog2(ALIGN);
   localparam int ADDR_W      = 12;
   localparam int LEN_W       = 13;
   localparam int NEED_W      = LEN_W + 1;
   localparam int IDX_W       = $clog2(MAX_SEGMENTS);
   localparam int CNT_W       = $clog2(MAX_SEGMENTS + 1);
   localparam int STORE_DEPTH = HEAP_BYTES / ALIGN;
   localparam int STORE_AW    = ADDR_W - ALIGN_SH;

   localparam logic [1:0] POL_BEST  = 2'd0;
   localparam logic [1:0] POL_FIRST = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic [1:0] CSR_FIT_POLICY = 2'd0;
   localparam logic [1:0] CSR_HEAP_BYTES = 2'd1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_WRITE,
      CELL_REMOVE,
      CELL_INSERT,
      CELL_LOAD
   } cell_op_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } seg_type;

   typedef struct packed {
      cell_op_type      op;
      logic [IDX_W-1:0] idx;
      seg_type          seg;
   } cell_cmd_type;

endpackage

FILE: rtl/free_list_heap_allocator.sv
// free-list heap allocator over a ring of segment cells
// request channel: start with req_mode, req_request_bytes, req_address is taken
// when busy is low; busy stays high until the result has been produced
// result channel: rsp_valid pulses for one cycle with rsp_status,
// rsp_address_out and rsp_granted_bytes; the receiver cannot stall it
// csr channel: csr_valid/csr_ready with csr_index and csr_data, taken only when idle;
// index 0 selects the fit policy, index 1 reloads the heap as one free segment
// an allocate makes one pass over the table, then an update state; a free reads its
// recorded size, checks it, makes the pass and updates, then merges when it joins
// both neighbours; a zero request, an empty table or a free with a bad address is
// answered from idle, and a free with no recorded size or past the heap from the
// check; a new request is taken only once the last is answered, set by the full
// rotation of the 16-cell ring and the registered read of the granted-size memory
// reset loads one free segment of 4096 bytes and best fit; the granted-size
// memory is not cleared
module free_list_heap_allocator import fsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_mode,
   input  logic [LEN_W-1:0]  req_request_bytes,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_address_out,
   output logic [LEN_W-1:0]  rsp_granted_bytes,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [LEN_W-1:0]  csr_data
);

   cell_cmd_type cmd;
   seg_type      segs [MAX_SEGMENTS];

   fsl_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_request_bytes (req_request_bytes),
      .req_address       (req_address),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_address_out   (rsp_address_out),
      .rsp_granted_bytes (rsp_granted_bytes),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .head              (segs[0]),
      .cmd               (cmd)
   );

   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      fsl_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .cell_idx (IDX_W'(g)),
         .prev_seg (segs[(g + MAX_SEGMENTS - 1) % MAX_SEGMENTS]),
         .next_seg (segs[(g + 1) % MAX_SEGMENTS]),
         .seg      (segs[g])
      );
   end

endmodule

FILE: rtl/fsl_cell.sv
module fsl_cell import fsl_pkg::*; (
   input  logic             clock,
   input  cell_cmd_type     cmd,
   input  logic [IDX_W-1:0] cell_idx,
   input  seg_type          prev_seg,
   input  seg_type          next_seg,
   output seg_type          seg
);

   seg_type seg_ff;
   seg_type seg_in;

   always_comb begin
      seg_in = seg_ff;
      unique case (cmd.op)
         CELL_HOLD: seg_in = seg_ff;
         CELL_ROTATE: seg_in = next_seg;
         CELL_WRITE: begin
            if (cell_idx == cmd.idx) seg_in = cmd.seg;
         end
         CELL_REMOVE: begin
            if (cell_idx >= cmd.idx) seg_in = next_seg;
         end
         CELL_INSERT: begin
            if (cell_idx > cmd.idx) seg_in = prev_seg;
            else if (cell_idx == cmd.idx) seg_in = cmd.seg;
         end
         CELL_LOAD: begin
            if (cell_idx == '0) seg_in = cmd.seg;
         end
         default: seg_in = seg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      seg_ff <= seg_in;
   end

   assign seg = seg_ff;

endmodule

FILE: rtl/fsl_ctrl.sv
module fsl_ctrl import fsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_mode,
   input  logic [LEN_W-1:0]  req_request_bytes,
   input  logic [ADDR_W-1:0] req_address,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [ADDR_W-1:0] rsp_address_out,
   output logic [LEN_W-1:0]  rsp_granted_bytes,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [LEN_W-1:0]  csr_data,
   input  seg_type           head,
   output cell_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_STORE_RD, S_CHECK, S_SCAN, S_APPLY, S_MERGE
   } state_type;

   state_type         state_ff;
   logic [1:0]        policy_ff;
   logic [LEN_W-1:0]  heap_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              mode_ff;
   logic [IDX_W-1:0]  k_ff;
   logic [NEED_W-1:0] need_ff;
   logic [NEED_W-1:0] bound_ff;
   logic              found_ff;
   logic              stop_ff;
   logic [IDX_W-1:0]  pick_idx_ff;
   logic [ADDR_W-1:0] pick_start_ff;
   logic [LEN_W-1:0]  pick_len_ff;
   logic [ADDR_W-1:0] hdr_ff;
   logic [LEN_W-1:0]  size_ff;
   logic [NEED_W-1:0] end_ff;
   logic [CNT_W-1:0]  pos_ff;
   logic [ADDR_W-1:0] lstart_ff;
   logic [LEN_W-1:0]  llen_ff;
   logic [NEED_W-1:0] lend_ff;
   logic              rfound_ff;
   logic [ADDR_W-1:0] rstart_ff;
   logic [LEN_W-1:0]  rlen_ff;
   logic              ovl_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_status_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [LEN_W-1:0]  rsp_gnt_ff;
   logic [LEN_W-1:0]  rd_data_ff;

   logic [LEN_W-1:0]  store_mem [STORE_DEPTH];

   logic [LEN_W-1:0]  usable;
   logic [NEED_W-1:0] need_w;
   logic [NEED_W-1:0] hend;
   logic              hvalid;
   logic              fits;
   logic              take;
   logic [NEED_W-1:0] left_w;
   logic              split;
   logic [LEN_W-1:0]  grant_w;
   logic              join_l;
   logic              join_r;
   logic [LEN_W-1:0]  merge_len;
   logic [NEED_W-1:0] fend_w;
   logic              st_we;
   logic [STORE_AW-1:0] st_wa;
   logic [LEN_W-1:0]  st_wd;

   always_comb begin
      usable = (csr_data > LEN_W'(HEAP_BYTES)) ? LEN_W'(HEAP_BYTES) : csr_data;
      usable = usable & ~LEN_W'(ALIGN - 1);
      need_w = ({1'b0, req_request_bytes} + NEED_W'(ALIGN - 1)) & ~NEED_W'(ALIGN - 1);
      need_w = need_w + NEED_W'(HDR_SPAN);
      if (need_w < NEED_W'(MIN_SPAN)) need_w = NEED_W'(MIN_SPAN);
      hend   = {2'b00, head.start} + {1'b0, head.len};
      hvalid = {1'b0, k_ff} < count_ff;
      fits   = {1'b0, head.len} >= need_ff;
      priority case (policy_ff)
         POL_FIRST: take = hvalid && fits && !found_ff;
         POL_WORST: take = hvalid && fits && !stop_ff && {1'b0, head.len} >= bound_ff;
         default:   take = hvalid && fits && !stop_ff && {1'b0, head.len} <= bound_ff;
      endcase
      left_w    = {1'b0, pick_len_ff} - need_ff;
      split     = left_w >= NEED_W'(MIN_SPAN);
      grant_w   = split ? need_ff[LEN_W-1:0] : pick_len_ff;
      join_l    = (pos_ff != '0) && (lend_ff == {2'b00, hdr_ff});
      join_r    = rfound_ff && ({2'b00, rstart_ff} == end_ff);
      merge_len = llen_ff + size_ff + (join_r ? rlen_ff : '0);
      fend_w    = {2'b00, hdr_ff} + {1'b0, rd_data_ff};
   end

   always_comb begin
      cmd     = '{op: CELL_HOLD, idx: '0, seg: '0};
      st_we   = 1'b0;
      st_wa   = hdr_ff[ADDR_W-1:ALIGN_SH];
      st_wd   = '0;
      if (reset) begin
         cmd = '{op: CELL_LOAD, idx: '0, seg: '{start: '0, len: LEN_W'(HEAP_BYTES)}};
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_index == CSR_HEAP_BYTES)
                  cmd = '{op: CELL_LOAD, idx: '0, seg: '{start: '0, len: usable}};
            end
            S_SCAN: cmd.op = CELL_ROTATE;
            S_APPLY: begin
               if (!mode_ff) begin
                  if (found_ff) begin
                     st_we = 1'b1;
                     st_wa = pick_start_ff[ADDR_W-1:ALIGN_SH];
                     st_wd = grant_w;
                     if (split)
                        cmd = '{op: CELL_WRITE, idx: pick_idx_ff,
                                seg: '{start: pick_start_ff + need_ff[ADDR_W-1:0],
                                       len: left_w[LEN_W-1:0]}};
                     else
                        cmd = '{op: CELL_REMOVE, idx: pick_idx_ff, seg: '0};
                  end
               end else if (!ovl_ff) begin
                  if (join_l) begin
                     st_we = 1'b1;
                     cmd = '{op: CELL_WRITE, idx: IDX_W'(pos_ff - 1'b1),
                             seg: '{start: lstart_ff, len: merge_len}};
                  end else if (join_r) begin
                     st_we = 1'b1;
                     cmd = '{op: CELL_WRITE, idx: pos_ff[IDX_W-1:0],
                             seg: '{start: hdr_ff, len: rlen_ff + size_ff}};
                  end else if (count_ff < CNT_W'(MAX_SEGMENTS)) begin
                     st_we = 1'b1;
                     cmd = '{op: CELL_INSERT, idx: pos_ff[IDX_W-1:0],
                             seg: '{start: hdr_ff, len: size_ff}};
                  end
               end
            end
            S_MERGE: cmd = '{op: CELL_REMOVE, idx: pos_ff[IDX_W-1:0], seg: '0};
            default: cmd.op = CELL_HOLD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_wa] <= st_wd;
      rd_data_ff <= store_mem[hdr_ff[ADDR_W-1:ALIGN_SH]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POL_BEST;
         heap_ff      <= LEN_W'(HEAP_BYTES);
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_index == CSR_FIT_POLICY) policy_ff <= csr_data[1:0];
               if (csr_valid && csr_index == CSR_HEAP_BYTES) begin
                  heap_ff  <= usable;
                  count_ff <= (usable >= LEN_W'(MIN_SPAN)) ? CNT_W'(1) : '0;
               end
               if (start) begin
                  mode_ff       <= req_mode;
                  k_ff          <= '0;
                  found_ff      <= 1'b0;
                  stop_ff       <= 1'b0;
                  need_ff       <= need_w;
                  bound_ff      <= (policy_ff == POL_WORST) ? '0 : '1;
                  pos_ff        <= '0;
                  rfound_ff     <= 1'b0;
                  ovl_ff        <= 1'b0;
                  rsp_status_ff <= ST_OK;
                  rsp_addr_ff   <= '0;
                  rsp_gnt_ff    <= '0;
                  hdr_ff        <= req_address - ADDR_W'(HDR_SPAN);
                  if (!req_mode) begin
                     if (req_request_bytes == '0 || count_ff == '0) begin
                        rsp_status_ff <= ST_FAIL;
                        rsp_valid_ff  <= 1'b1;
                     end else begin
                        state_ff <= S_SCAN;
                     end
                  end else if (req_address < ADDR_W'(HDR_SPAN) ||
                               req_address[ALIGN_SH-1:0] != '0) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= S_STORE_RD;
                  end
               end
            end
            S_STORE_RD: state_ff <= S_CHECK;
            S_CHECK: begin
               size_ff <= rd_data_ff;
               end_ff  <= fend_w;
               if (rd_data_ff == '0 || fend_w > {1'b0, heap_ff}) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               k_ff <= k_ff + 1'b1;
               if (!mode_ff) begin
                  if (take) begin
                     found_ff      <= 1'b1;
                     pick_idx_ff   <= k_ff;
                     pick_start_ff <= head.start;
                     pick_len_ff   <= head.len;
                     bound_ff      <= {1'b0, head.len};
                     if ({1'b0, head.len} == need_ff) stop_ff <= 1'b1;
                  end
               end else if (hvalid) begin
                  if ({2'b00, head.start} < end_ff && hend > {2'b00, hdr_ff})
                     ovl_ff <= 1'b1;
                  if (head.start < hdr_ff) begin
                     pos_ff    <= CNT_W'(k_ff) + 1'b1;
                     lstart_ff <= head.start;
                     llen_ff   <= head.len;
                     lend_ff   <= hend;
                  end else if (!rfound_ff) begin
                     rfound_ff <= 1'b1;
                     rstart_ff <= head.start;
                     rlen_ff   <= head.len;
                  end
               end
               if (k_ff == IDX_W'(MAX_SEGMENTS - 1)) state_ff <= S_APPLY;
            end
            S_APPLY: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b1;
               if (!mode_ff) begin
                  if (!found_ff) begin
                     rsp_status_ff <= ST_FAIL;
                  end else begin
                     rsp_addr_ff <= pick_start_ff + ADDR_W'(HDR_SPAN);
                     rsp_gnt_ff  <= grant_w;
                     if (!split) count_ff <= count_ff - 1'b1;
                  end
               end else if (!ovl_ff) begin
                  if (join_l) begin
                     rsp_gnt_ff <= size_ff;
                     if (join_r) begin
                        rsp_valid_ff <= 1'b0;
                        state_ff     <= S_MERGE;
                     end
                  end else if (join_r) begin
                     rsp_gnt_ff <= size_ff;
                  end else if (count_ff < CNT_W'(MAX_SEGMENTS)) begin
                     rsp_gnt_ff <= size_ff;
                     count_ff   <= count_ff + 1'b1;
                  end else begin
                     rsp_status_ff <= ST_FULL;
                  end
               end
            end
            S_MERGE: begin
               count_ff     <= count_ff - 1'b1;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy              = state_ff != S_IDLE;
   assign csr_ready         = state_ff == S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_address_out   = rsp_addr_ff;
   assign rsp_granted_bytes = rsp_gnt_ff;

endmodule

FILE: rtl/fsl_checker.sv
module fsl_checker import fsl_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [1:0]        rsp_status,
   input logic [ADDR_W-1:0] rsp_address_out,
   input logic [LEN_W-1:0]  rsp_granted_bytes
);

   // a result only shows once the block is idle again
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("request neither started nor answered");

   a_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_granted_bytes == '0 && rsp_address_out == '0))
      else $error("failed request carries data");

endmodule

bind free_list_heap_allocator fsl_checker u_fsl_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_status        (rsp_status),
   .rsp_address_out   (rsp_address_out),
   .rsp_granted_bytes (rsp_granted_bytes)
);

FILE: verif/free_list_heap_allocator_test.sv
`timescale 1ns / 1ps

module free_list_heap_allocator_test;
   import fsl_pkg::*;

   typedef struct {
      logic [1:0]        status;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  bytes;
   } heap_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_mode = 1'b0;
   logic [LEN_W-1:0]  req_request_bytes = '0;
   logic [ADDR_W-1:0] req_address = '0;
   logic              rsp_valid;
   logic [1:0]        rsp_status;
   logic [ADDR_W-1:0] rsp_address_out;
   logic [LEN_W-1:0]  rsp_granted_bytes;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [1:0]        csr_index = '0;
   logic [LEN_W-1:0]  csr_data = '0;

   free_list_heap_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_request_bytes(req_request_bytes),
      .req_address(req_address), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_address_out(rsp_address_out), .rsp_granted_bytes(rsp_granted_bytes),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // allocator state as seen from outside
   int seg_start [MAX_SEGMENTS];
   int seg_len [MAX_SEGMENTS];
   int seg_cnt;
   int fit_sel;
   int heap_limit;
   int size_store [STORE_DEPTH];
   heap_result_type pending_results [$];
   int live_blocks [$];
   int granted_addrs [$];

   int  errors = 0;
   int  cycles = 0;
   int  requests = 0;
   int  results = 0;
   int  allocs_ok = 0;
   int  frees_ok = 0;
   int  table_full_hits = 0;
   bit  gaps_on = 1'b1;

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic void load_heap(int value);
      int usable;
      usable = value > HEAP_BYTES ? HEAP_BYTES : value;
      usable = usable / ALIGN * ALIGN;
      heap_limit = usable;
      seg_start[0] = 0;
      seg_len[0] = usable;
      seg_cnt = usable >= MIN_SPAN ? 1 : 0;
   endfunction

   function automatic void drop_segment(int i);
      for (int k = i; k < seg_cnt - 1; k++) begin
         seg_start[k] = seg_start[k + 1];
         seg_len[k] = seg_len[k + 1];
      end
      seg_cnt--;
   endfunction

   function automatic int pick_segment(int need);
      int     pick;
      longint bound;
      pick = seg_cnt;
      if (fit_sel == POL_FIRST) begin
         for (int i = 0; i < seg_cnt; i++)
            if (seg_len[i] >= need) return i;
         return pick;
      end
      bound = (fit_sel == POL_WORST) ? 0 : 64'hffffffff;
      for (int i = 0; i < seg_cnt; i++) begin
         if (seg_len[i] >= need && ((fit_sel == POL_WORST) ? seg_len[i] >= bound
                                                            : seg_len[i] <= bound)) begin
            pick = i;
            bound = seg_len[i];
            if (bound == need) break;
         end
      end
      return pick;
   endfunction

   function automatic heap_result_type predict_alloc(int req);
      heap_result_type r;
      int need, i, base, rest;
      r = '{ST_OK, '0, '0};
      if (req == 0 || seg_cnt == 0) begin
         r.status = ST_FAIL;
         return r;
      end
      need = (req + ALIGN - 1) / ALIGN * ALIGN + HDR_SPAN;
      if (need < MIN_SPAN) need = MIN_SPAN;
      i = pick_segment(need);
      if (i >= seg_cnt) begin
         r.status = ST_FAIL;
         return r;
      end
      base = seg_start[i];
      rest = seg_len[i] - need;
      if (rest >= MIN_SPAN) begin
         seg_start[i] = base + need;
         seg_len[i] = rest;
      end else begin
         need = seg_len[i];
         drop_segment(i);
      end
      size_store[base / ALIGN] = need;
      r.addr = ADDR_W'(base + HDR_SPAN);
      r.bytes = LEN_W'(need);
      return r;
   endfunction

   function automatic heap_result_type predict_free(int addr);
      heap_result_type r;
      int  hdr, idx, size, blk_end, pos;
      bit  join_l, join_r;
      r = '{ST_OK, '0, '0};
      pos = 0;
      if (addr < HDR_SPAN || addr % ALIGN != 0) return r;
      hdr = addr - HDR_SPAN;
      idx = hdr / ALIGN;
      if (idx >= STORE_DEPTH) return r;
      size = size_store[idx];
      if (size == 0) return r;
      blk_end = hdr + size;
      if (blk_end > heap_limit) return r;
      for (int i = 0; i < seg_cnt; i++) begin
         if (seg_start[i] < blk_end && seg_start[i] + seg_len[i] > hdr) return r;
         if (seg_start[i] < hdr) pos = i + 1;
      end
      join_l = pos > 0 && seg_start[pos - 1] + seg_len[pos - 1] == hdr;
      join_r = pos < seg_cnt && seg_start[pos] == blk_end;
      if (join_l) begin
         seg_len[pos - 1] += size;
         if (join_r) begin
            seg_len[pos - 1] += seg_len[pos];
            drop_segment(pos);
         end
      end else if (join_r) begin
         seg_start[pos] = hdr;
         seg_len[pos] += size;
      end else begin
         if (seg_cnt >= MAX_SEGMENTS) begin
            r.status = ST_FULL;
            return r;
         end
         for (int k = seg_cnt; k > pos; k--) begin
            seg_start[k] = seg_start[k - 1];
            seg_len[k] = seg_len[k - 1];
         end
         seg_start[pos] = hdr;
         seg_len[pos] = size;
         seg_cnt++;
      end
      size_store[idx] = 0;
      r.bytes = LEN_W'(size);
      return r;
   endfunction

   task automatic send_request(bit mode, int req_bytes, int addr);
      heap_result_type r;
      @(negedge clock);
      start = 1'b1;
      req_mode = mode;
      req_request_bytes = LEN_W'(req_bytes);
      req_address = ADDR_W'(addr);
      do @(posedge clock); while (busy);
      requests++;
      if (mode == 1'b0) begin
         r = predict_alloc(req_bytes);
         if (r.status == ST_OK) begin
            allocs_ok++;
            live_blocks.push_back(r.addr);
            granted_addrs.push_back(r.addr);
         end
      end else begin
         r = predict_free(addr);
         if (r.status == ST_FULL) table_full_hits++;
         if (r.bytes != 0) begin
            frees_ok++;
            foreach (live_blocks[k])
               if (live_blocks[k] == addr) begin
                  live_blocks.delete(k);
                  break;
               end
         end
      end
      pending_results.push_back(r);
   endtask

   task automatic maybe_pause();
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = LEN_W'(value);
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FIT_POLICY) fit_sel = value & 3;
      else if (idx == CSR_HEAP_BYTES) begin
         load_heap(value & 16'h1fff);
         live_blocks.delete();
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item();
      int pick, addr;
      pick = $urandom_range(0, 99);
      if (pick < 55 || live_blocks.size() == 0 && pick < 90) begin
         if ($urandom_range(0, 9) == 0) send_request(1'b0, $urandom_range(0, 4096), 0);
         else send_request(1'b0, $urandom_range(1, 300), 0);
      end else if (pick < 90) begin
         send_request(1'b1, 0, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      end else if (pick < 95 && granted_addrs.size() != 0) begin
         send_request(1'b1, 0, granted_addrs[$urandom_range(0, granted_addrs.size() - 1)]);
      end else begin
         addr = $urandom_range(0, 4095);
         if (addr % ALIGN == 0) addr = $urandom_range(0, HDR_SPAN - 1);
         send_request(1'b1, $urandom_range(0, 8191), addr);
      end
      maybe_pause();
   endtask

   // extremes of size, zero request, ignored frees, double free, policy three
   task automatic test_directed();
      send_request(1'b0, 0, 12'hfff);
      send_request(1'b0, 4096, 0);
      send_request(1'b1, 0, 12'hfff);
      send_request(1'b0, 1, 0);
      send_request(1'b0, 4096, 0);
      send_request(1'b0, 4079, 0);
      send_request(1'b1, 0, 0);
      send_request(1'b1, 0, 4);
      send_request(1'b1, 0, live_blocks[0]);
      send_request(1'b1, 0, granted_addrs[0]);
      send_request(1'b1, 0, live_blocks[0]);
      send_request(1'b0, 4088, 0);
      send_request(1'b1, 0, live_blocks[0]);
      drain();
      csr_write(CSR_FIT_POLICY, 3);
      csr_write(2'd2, 12);
      csr_write(2'd3, 0);
      send_request(1'b0, 100, 0);
      send_request(1'b0, 8, 0);
      drain();
   endtask

   // scatter small blocks so that a lone free finds the table full
   task automatic test_table_full();
      int blocks [$];
      csr_write(CSR_HEAP_BYTES, HEAP_BYTES);
      csr_write(CSR_FIT_POLICY, POL_FIRST);
      repeat (40) send_request(1'b0, 8, 0);
      drain();
      blocks = live_blocks;
      for (int k = 0; k < 40; k += 2) send_request(1'b1, 0, blocks[k]);
      send_request(1'b1, 0, blocks[1]);
      send_request(1'b1, 0, blocks[3]);
      drain();
   endtask

   task automatic test_random_policies();
      int heaps [5] = '{4096, 64, 1000, 8191, 2048};
      for (int p = 0; p < 4; p++) begin
         for (int h = 0; h < 5; h++) begin
            csr_write(CSR_FIT_POLICY, p);
            csr_write(CSR_HEAP_BYTES, heaps[h]);
            repeat (h == 1 ? 15 : 40) random_item();
            drain();
         end
      end
      csr_write(CSR_HEAP_BYTES, 15);
      repeat (5) random_item();
      drain();
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      csr_write(CSR_FIT_POLICY, POL_WORST);
      csr_write(CSR_HEAP_BYTES, HEAP_BYTES);
      repeat (80) random_item();
      drain();
   endtask

   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid) begin
         results++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_status, -1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_address_out !== want.addr)
               report_mismatch("address_out", rsp_address_out, want.addr);
            if (rsp_granted_bytes !== want.bytes)
               report_mismatch("granted_bytes", rsp_granted_bytes, want.bytes);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("free_list_heap_allocator_test: FAIL");
         $finish;
      end
   end

   initial begin
      fit_sel = POL_BEST;
      load_heap(HEAP_BYTES);
      foreach (size_store[k]) size_store[k] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random_policies();
      test_back_to_back();
      if (pending_results.size() != 0)
         report_mismatch("results outstanding", pending_results.size(), 0);
      $display("%0d requests, %0d results: %0d allocations and %0d frees granted,",
               requests, results, allocs_ok, frees_ok);
      $display("%0d frees hit a full table, over four fit policies and six heap sizes",
               table_full_hits);
      if (errors == 0) begin
         $display("free_list_heap_allocator_test: PASS");
      end else begin
         $display("free_list_heap_allocator_test: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fsl_pkg.sv
rtl/fsl_cell.sv
rtl/fsl_ctrl.sv
rtl/free_list_heap_allocator.sv
rtl/fsl_checker.sv
verif/free_list_heap_allocator_test.sv
